// File: hw/rtl/ftd_pkg.sv
package ftd_pkg;

   localparam int MAX_FRAC_DIGITS = 9;
   localparam int INT_DIGITS      = 10;
   localparam int BCD_DIGITS      = 10;
   localparam int BCD_W           = 4 * BCD_DIGITS;
   localparam int BIN_W           = 32;
   localparam int FDIG_W          = 30;
   localparam int PROD_W          = 54;
   localparam int REM_W           = 24;
   localparam int DABBLE_STAGES   = 4;
   localparam int MAX_CHARS       = 1 + INT_DIGITS + 1 + MAX_FRAC_DIGITS;

   localparam logic [31:0] INT_LIMIT = (INT_DIGITS >= 10) ? 32'd2147483647
                                                          : 32'(10**INT_DIGITS - 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [3:0] FRAC_DIGITS_RESET = 4'd2;

   typedef struct packed {
      logic       neg;
      logic       sat;
      logic [3:0] k;
   } meta_type;

   typedef struct packed {
      meta_type           meta;
      logic [BIN_W-1:0]   int_bin;
      logic [BCD_W-1:0]   int_bcd;
      logic [BIN_W-1:0]   frac_bin;
      logic [BCD_W-1:0]   frac_bcd;
   } conv_type;

   function automatic logic [FDIG_W-1:0] pow10(input logic [3:0] k);
      logic [FDIG_W-1:0] r;
      case (k)
         4'd0:    r = 30'd1;
         4'd1:    r = 30'd10;
         4'd2:    r = 30'd100;
         4'd3:    r = 30'd1000;
         4'd4:    r = 30'd10000;
         4'd5:    r = 30'd100000;
         4'd6:    r = 30'd1000000;
         4'd7:    r = 30'd10000000;
         4'd8:    r = 30'd100000000;
         4'd9:    r = 30'd1000000000;
         default: r = 30'd1;
      endcase
      return r;
   endfunction

   // eight shift-and-add-3 steps
   function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_i,
                                                 input logic [7:0] bits_i);
      logic [BCD_W-1:0] acc;
      acc = bcd_i;
      for (int b = 7; b >= 0; b--) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (acc[d*4 +: 4] >= 4'd5) begin
               acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
            end
         end
         acc = {acc[BCD_W-2:0], bits_i[b]};
      end
      return acc;
   endfunction

endpackage

// File: hw/rtl/float_to_decimal_text_top.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | req_value_bits[31:0]
// rsp     | out       | rsp_valid / rsp_ready  | rsp_character[7:0], rsp_last_char, rsp_saturated
// csr     | in        | csr_valid / csr_ready  | csr_fraction_digits[3:0]
//
// Seven register stages (unpack, multiply by 10^k, scale, four binary-to-BCD
// stages), then a character emitter that sends one character per cycle when
// rsp is not stalled. A number's text has 1 to 21 characters; the emitter
// computes that length as it loads the number from the last stage.
// Reset clears all valid bits; fraction_digits returns to 2.
// A stall on rsp holds the whole pipeline once its last stage is full; nothing is lost or repeated.
module float_to_decimal_text_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_last_char,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_fraction_digits
);
   import ftd_pkg::*;

   logic [3:0]                   frac_digits_ff;
   logic [DABBLE_STAGES:0]       conv_valid;
   conv_type                     conv_data [0:DABBLE_STAGES];
   logic                         adv;
   logic                         load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_digits_ff <= FRAC_DIGITS_RESET;
      end else if (csr_valid) begin
         frac_digits_ff <= csr_fraction_digits;
      end
   end

   // whole pipeline moves together unless its tail is full and blocked
   assign adv       = !conv_valid[DABBLE_STAGES] || load;
   assign req_ready = adv;

   ftd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .value_bits  (req_value_bits),
      .frac_digits (frac_digits_ff),
      .out_valid   (conv_valid[0]),
      .out_data    (conv_data[0])
   );

   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
      ftd_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (conv_valid[g]),
         .in_data   (conv_data[g]),
         .out_valid (conv_valid[g+1]),
         .out_data  (conv_data[g+1])
      );
   end

   ftd_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (conv_valid[DABBLE_STAGES]),
      .in_data       (conv_data[DABBLE_STAGES]),
      .load          (load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// File: hw/rtl/ftd_front.sv
module ftd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [31:0]          value_bits,
   input  logic [3:0]           frac_digits,
   output logic                 out_valid,
   output ftd_pkg::conv_type    out_data
);
   import ftd_pkg::*;

   // stage 1: unpack and split
   logic                 s1_valid_ff;
   meta_type             s1_meta_ff, s1_meta_in;
   logic [31:0]          s1_ipart_ff, s1_ipart_in;
   logic [REM_W-1:0]     s1_rem_ff, s1_rem_in;
   logic [5:0]           s1_sh_ff, s1_sh_in;

   logic        sign;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [23:0] mant;
   logic [7:0]  sh_full;
   logic [2:0]  up_sh;
   logic [3:0]  k_c;
   logic        big;

   always_comb begin
      sign    = value_bits[31];
      expo    = value_bits[30:23];
      frac    = value_bits[22:0];
      mant    = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      k_c     = (frac_digits > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : frac_digits;
      big     = (expo == 8'hFF) || (expo >= 8'd158);
      sh_full = (expo == 8'd0) ? 8'd149 : (8'd150 - expo);
      up_sh   = 3'(expo - 8'd150);
      s1_ipart_in = 32'd0;
      s1_rem_in   = '0;
      s1_sh_in    = 6'd0;
      if (big) begin
         s1_ipart_in = 32'd0;
      end else if (expo >= 8'd150) begin
         s1_ipart_in = {8'd0, mant} << up_sh;
      end else if (sh_full >= 8'd32) begin
         s1_rem_in = mant;
         s1_sh_in  = (sh_full > 8'd63) ? 6'd63 : 6'(sh_full);
      end else begin
         s1_ipart_in = {8'd0, mant} >> sh_full[4:0];
         s1_rem_in   = mant & 24'((32'd1 << sh_full[4:0]) - 32'd1);
         s1_sh_in    = 6'(sh_full);
      end
      s1_meta_in.neg = sign && (mant != 24'd0) && !((expo == 8'hFF) && (frac != 23'd0));
      s1_meta_in.sat = big || (s1_ipart_in > INT_LIMIT);
      s1_meta_in.k   = k_c;
   end

   // stage 2: fraction times 10^k
   logic                 s2_valid_ff;
   meta_type             s2_meta_ff;
   logic [31:0]          s2_ipart_ff;
   logic [5:0]           s2_sh_ff;
   logic [PROD_W-1:0]    s2_prod_ff, s2_prod_in;

   assign s2_prod_in = PROD_W'(s1_rem_ff) * PROD_W'(pow10(s1_meta_ff.k));

   // stage 3: scale back down, apply saturation
   logic                 s3_valid_ff;
   conv_type             s3_data_ff, s3_data_in;
   logic [PROD_W-1:0]    fdig_full;

   always_comb begin
      fdig_full           = s2_prod_ff >> s2_sh_ff;
      s3_data_in.meta     = s2_meta_ff;
      s3_data_in.int_bin  = s2_meta_ff.sat ? INT_LIMIT : s2_ipart_ff;
      s3_data_in.frac_bin = s2_meta_ff.sat ? '0 : {2'b00, fdig_full[FDIG_W-1:0]};
      s3_data_in.int_bcd  = '0;
      s3_data_in.frac_bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff  <= s1_meta_in;
         s1_ipart_ff <= s1_ipart_in;
         s1_rem_ff   <= s1_rem_in;
         s1_sh_ff    <= s1_sh_in;
         s2_meta_ff  <= s1_meta_ff;
         s2_ipart_ff <= s1_ipart_ff;
         s2_sh_ff    <= s1_sh_ff;
         s2_prod_ff  <= s2_prod_in;
         s3_data_ff  <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

// File: hw/rtl/ftd_dabble.sv
module ftd_dabble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  ftd_pkg::conv_type    in_data,
   output logic                 out_valid,
   output ftd_pkg::conv_type    out_data
);
   import ftd_pkg::*;

   logic     valid_ff;
   conv_type data_ff, data_in;

   always_comb begin
      data_in          = in_data;
      data_in.int_bcd  = dabble8(in_data.int_bcd, in_data.int_bin[BIN_W-1 -: 8]);
      data_in.frac_bcd = dabble8(in_data.frac_bcd, in_data.frac_bin[BIN_W-1 -: 8]);
      data_in.int_bin  = in_data.int_bin << 8;
      data_in.frac_bin = in_data.frac_bin << 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/ftd_emit.sv
module ftd_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ftd_pkg::conv_type    in_data,
   output logic                 load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_character,
   output logic                 rsp_last_char,
   output logic                 rsp_saturated
);
   import ftd_pkg::*;

   logic                 text_valid_ff, text_valid_in;
   meta_type             meta_ff;
   logic [BCD_W-1:0]     int_bcd_ff;
   logic [BCD_W-1:0]     frac_bcd_ff;
   logic [3:0]           n_ff, n_in;
   logic [4:0]           len_ff, len_in;
   logic [4:0]           idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, sat_ff;

   logic                 out_adv;
   logic                 is_last;
   logic [4:0]           p;
   logic [3:0]           di;

   // integer digit count from the leading non-zero BCD digit
   always_comb begin
      n_in = 4'd1;
      for (int d = 1; d < BCD_DIGITS; d++) begin
         if (in_data.int_bcd[d*4 +: 4] != 4'd0) begin
            n_in = 4'(d + 1);
         end
      end
      if (n_in > 4'(INT_DIGITS)) begin
         n_in = 4'(INT_DIGITS);
      end
      len_in = 5'(in_data.meta.neg) + 5'(n_in)
             + ((in_data.meta.k != 4'd0) ? (5'(in_data.meta.k) + 5'd1) : 5'd0);
   end

   assign out_adv = !rsp_valid_ff || rsp_ready;
   assign is_last = (idx_ff + 5'd1) == len_ff;
   assign load    = in_valid && (!text_valid_ff || (out_adv && is_last));

   always_comb begin
      p  = idx_ff - 5'(meta_ff.neg);
      di = 4'd0;
      char_in = CHAR_POINT;
      if (meta_ff.neg && idx_ff == 5'd0) begin
         char_in = CHAR_MINUS;
      end else if (p < 5'(n_ff)) begin
         di      = 4'(5'(n_ff) - 5'd1 - p);
         char_in = CHAR_ZERO + {4'd0, int_bcd_ff[di*4 +: 4]};
      end else if (p == 5'(n_ff)) begin
         char_in = CHAR_POINT;
      end else begin
         di      = 4'(5'(meta_ff.k) + 5'(n_ff) - p);
         char_in = CHAR_ZERO + {4'd0, frac_bcd_ff[di*4 +: 4]};
      end
   end

   always_comb begin
      text_valid_in = text_valid_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (out_adv) begin
         rsp_valid_in = text_valid_ff;
         if (text_valid_ff) begin
            idx_in = idx_ff + 5'd1;
            if (is_last) begin
               text_valid_in = 1'b0;
            end
         end
      end
      if (load) begin
         text_valid_in = 1'b1;
         idx_in        = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_valid_ff <= 1'b0;
         idx_ff        <= 5'd0;
         len_ff        <= 5'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         text_valid_ff <= text_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (load) begin
            len_ff <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff     <= in_data.meta;
         int_bcd_ff  <= in_data.int_bcd;
         frac_bcd_ff <= in_data.frac_bcd;
         n_ff        <= n_in;
      end
      if (out_adv && text_valid_ff) begin
         char_ff <= char_in;
         last_ff <= is_last;
         sat_ff  <= meta_ff.sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      text_valid_ff |-> idx_ff < len_ff)
      else $error("emit index beyond text length");
   a_len_bounds: assert property (@(posedge clock) disable iff (reset)
      text_valid_ff |-> (len_ff >= 5'd1 && len_ff <= 5'(MAX_CHARS)))
      else $error("text length out of range");
   a_text_held: assert property (@(posedge clock) disable iff (reset)
      (out_adv && text_valid_ff && !is_last) |=> text_valid_ff)
      else $error("text dropped before its last character");
`endif

endmodule
